// ----- rtl/assert_macros.svh -----
// assertion macros included by the allocator core rtl
// active in simulation, empty when SYNTHESIS is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/drsa_pkg.sv -----
// shared types and constants of the dma region stack allocator
// no dependencies
package drsa_pkg;

    localparam int MAX_ENTRIES    = 16;
    localparam int IDX_W          = $clog2(MAX_ENTRIES);
    localparam int CNT_W          = $clog2(MAX_ENTRIES + 1);
    localparam int PAGE_SHIFT_MAX = 20;

    // request kinds
    localparam logic [1:0] REQ_ALLOC    = 2'd0;
    localparam logic [1:0] REQ_FREE     = 2'd1;
    localparam logic [1:0] REQ_FREE_ALL = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_SPACE   = 2'd1;
    localparam logic [1:0] ST_BAD_HANDLE = 2'd2;
    localparam logic [1:0] ST_TABLE_FULL = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_PAGE_SHIFT  = 2'd0;
    localparam logic [1:0] CFG_REGION_SIZE = 2'd1;
    localparam logic [1:0] CFG_IOVA_BASE   = 2'd2;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_DECODE,
        FSM_CHECK,
        FSM_SCAN,
        FSM_DONE
    } fsm_state_t;

endpackage

// ----- rtl/dma_region_stack_allocator_core.sv -----
// top level of the dma region stack allocator
// depends on drsa_pkg and assert_macros.svh
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tuser req_type, tdata size, handle
// m_*       out  m_tvalid/m_tready  tuser status, tdata handle/addr/offset/size/count
// cfg_*     in   cfg_wr_en          cfg_index, cfg_wdata
//
// one request at a time: allocate steps through decode, check and done; a bad free,
// free-all or unused kind through decode and done; a good free through decode, a scan
// of the offset/size memory for the highest live end at one read per cycle, and done.
// a new request is taken while the previous result still waits in the output register.
// a result that cannot leave holds the engine in its final state until m_tready.
// synchronous active-low reset clears valid bits, top, count and control registers and
// sets page shift to 12; no memory clearing pass is needed.
`include "assert_macros.svh"

module dma_region_stack_allocator_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // size[31:0], handle[35:32], zero fill
    input  logic [1:0]   s_tuser,   // req_type[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // alloc_handle[3:0], bus_addr[35:4], buf_offset[67:36],
                                    // alloc_size[99:68], live_count[104:100], zero fill
    output logic [1:0]   m_tuser,   // status[1:0]
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);

    localparam int IW = drsa_pkg::IDX_W;
    localparam int CW = drsa_pkg::CNT_W;
    localparam int NE = drsa_pkg::MAX_ENTRIES;

    // control state
    drsa_pkg::fsm_state_t state_reg, state_next;
    logic [NE-1:0] valid_reg, valid_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   top_reg, top_next;
    logic [CW-1:0] scan_cnt_reg, scan_cnt_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          m_valid_reg, m_valid_next;
    logic [4:0]    page_shift_reg;
    logic [31:0]   region_size_reg;
    logic [31:0]   iova_base_reg;

    // payload
    logic [1:0]    req_reg;
    logic [31:0]   size_reg;
    logic [IW-1:0] handle_reg;
    logic [32:0]   rounded_reg, rounded_next;
    logic [32:0]   best_reg, best_next;
    logic [IW-1:0] rd_idx_reg;
    logic [1:0]    res_status_reg, res_status_next;
    logic [IW-1:0] res_handle_reg, res_handle_next;
    logic [31:0]   res_addr_reg, res_addr_next;
    logic [31:0]   res_off_reg, res_off_next;
    logic [31:0]   res_size_reg, res_size_next;
    logic [1:0]    out_status_reg;
    logic [IW-1:0] out_handle_reg;
    logic [31:0]   out_addr_reg;
    logic [31:0]   out_off_reg;
    logic [31:0]   out_size_reg;
    logic [CW-1:0] out_count_reg;
    logic          out_load;

    // offset/size memory, offset in the low half
    logic [63:0]   mem [NE];
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [63:0]   mem_wdata;
    logic [IW-1:0] mem_raddr;
    logic [63:0]   rd_data_reg;

    // helpers
    logic [4:0]    shift_sat;
    logic [32:0]   page_mask;
    logic [33:0]   alloc_end;
    logic [32:0]   entry_end;
    logic [IW-1:0] free_slot;
    logic          slot_found;

    logic          s_xfer;
    assign s_xfer   = s_tvalid && s_tready;
    assign s_tready = (state_reg == drsa_pkg::FSM_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'd0, out_count_reg, out_size_reg, out_off_reg, out_addr_reg,
                       out_handle_reg};

    // page rounding terms
    assign shift_sat = (page_shift_reg > 5'(drsa_pkg::PAGE_SHIFT_MAX))
                       ? 5'(drsa_pkg::PAGE_SHIFT_MAX) : page_shift_reg;
    assign page_mask = (33'd1 << shift_sat) - 33'd1;
    assign alloc_end = {2'b00, top_reg} + {1'b0, rounded_reg};
    assign entry_end = {1'b0, rd_data_reg[31:0]} + {1'b0, rd_data_reg[63:32]};

    // lowest free slot
    always_comb begin
        free_slot  = '0;
        slot_found = 1'b0;
        for (int i = NE - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_slot  = IW'(i);
                slot_found = 1'b1;
            end
        end
    end

    // next state and datapath control
    always_comb begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        top_next        = top_reg;
        scan_cnt_next   = scan_cnt_reg;
        rd_pend_next    = 1'b0;
        m_valid_next    = m_valid_reg;
        rounded_next    = rounded_reg;
        best_next       = best_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_addr_next   = res_addr_reg;
        res_off_next    = res_off_reg;
        res_size_next   = res_size_reg;
        mem_we          = 1'b0;
        mem_waddr       = free_slot;
        mem_wdata       = {rounded_reg[31:0], top_reg};
        mem_raddr       = scan_cnt_reg[IW-1:0];
        out_load        = 1'b0;

        // output register drains independently
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            drsa_pkg::FSM_IDLE: begin
                if (s_xfer) begin
                    state_next = drsa_pkg::FSM_DECODE;
                end
            end
            drsa_pkg::FSM_DECODE: begin
                res_status_next = drsa_pkg::ST_OK;
                res_handle_next = '0;
                res_addr_next   = '0;
                res_off_next    = '0;
                res_size_next   = '0;
                state_next      = drsa_pkg::FSM_DONE;
                unique case (req_reg)
                    drsa_pkg::REQ_ALLOC: begin
                        rounded_next = ({1'b0, size_reg} + page_mask) & ~page_mask;
                        state_next   = drsa_pkg::FSM_CHECK;
                    end
                    drsa_pkg::REQ_FREE: begin
                        if (!valid_reg[handle_reg]) begin
                            res_status_next = drsa_pkg::ST_BAD_HANDLE;
                        end else begin
                            valid_next[handle_reg] = 1'b0;
                            count_next    = count_reg - CW'(1);
                            scan_cnt_next = '0;
                            best_next     = '0;
                            state_next    = drsa_pkg::FSM_SCAN;
                        end
                    end
                    drsa_pkg::REQ_FREE_ALL: begin
                        valid_next = '0;
                        count_next = '0;
                        top_next   = '0;
                    end
                    default: begin
                        // unused request kind answers ok with no change
                    end
                endcase
            end
            drsa_pkg::FSM_CHECK: begin
                state_next = drsa_pkg::FSM_DONE;
                if (alloc_end > {2'b00, region_size_reg}) begin
                    res_status_next = drsa_pkg::ST_NO_SPACE;
                end else if (!slot_found) begin
                    res_status_next = drsa_pkg::ST_TABLE_FULL;
                end else begin
                    mem_we                = 1'b1;
                    valid_next[free_slot] = 1'b1;
                    count_next            = count_reg + CW'(1);
                    res_handle_next       = free_slot;
                    res_off_next          = top_reg;
                    res_addr_next         = iova_base_reg + top_reg;
                    res_size_next         = rounded_reg[31:0];
                    top_next              = alloc_end[31:0];
                end
            end
            drsa_pkg::FSM_SCAN: begin
                // issue one read per cycle, fold the entry read last cycle
                if (scan_cnt_reg < CW'(NE)) begin
                    rd_pend_next  = 1'b1;
                    scan_cnt_next = scan_cnt_reg + CW'(1);
                end
                if (rd_pend_reg && valid_reg[rd_idx_reg] && (entry_end > best_reg)) begin
                    best_next = entry_end;
                end
                if (scan_cnt_reg == CW'(NE) && !rd_pend_reg) begin
                    top_next   = best_reg[31:0];
                    state_next = drsa_pkg::FSM_DONE;
                end
            end
            drsa_pkg::FSM_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = drsa_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = drsa_pkg::FSM_IDLE;
            end
        endcase
    end

    // control registers and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= drsa_pkg::FSM_IDLE;
            valid_reg       <= '0;
            count_reg       <= '0;
            top_reg         <= '0;
            scan_cnt_reg    <= '0;
            rd_pend_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
            page_shift_reg  <= 5'd12;
            region_size_reg <= '0;
            iova_base_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            count_reg    <= count_next;
            top_reg      <= top_next;
            scan_cnt_reg <= scan_cnt_next;
            rd_pend_reg  <= rd_pend_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    drsa_pkg::CFG_PAGE_SHIFT:  page_shift_reg  <= cfg_wdata[4:0];
                    drsa_pkg::CFG_REGION_SIZE: region_size_reg <= cfg_wdata;
                    drsa_pkg::CFG_IOVA_BASE:   iova_base_reg   <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            req_reg    <= s_tuser;
            size_reg   <= s_tdata[31:0];
            handle_reg <= s_tdata[32 +: IW];
        end
        rounded_reg    <= rounded_next;
        best_reg       <= best_next;
        rd_idx_reg     <= mem_raddr;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_addr_reg   <= res_addr_next;
        res_off_reg    <= res_off_next;
        res_size_reg   <= res_size_next;
        if (out_load) begin
            out_status_reg <= res_status_reg;
            out_handle_reg <= res_handle_reg;
            out_addr_reg   <= res_addr_reg;
            out_off_reg    <= res_off_reg;
            out_size_reg   <= res_size_reg;
            out_count_reg  <= count_reg;
        end
    end

    // offset/size memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // assertions
    `ASSERT_IMPLIES(a_count_matches, aclk, aresetn, 1'b1, count_reg == CW'($countones(valid_reg)))
    `ASSERT_NEXT(a_scan_valid_stable, aclk, aresetn, state_reg == drsa_pkg::FSM_SCAN, $stable(valid_reg))
    `ASSERT_IMPLIES(a_scan_bound, aclk, aresetn, state_reg == drsa_pkg::FSM_SCAN, scan_cnt_reg <= CW'(NE))
    `ASSERT_NEXT(a_load_sets_valid, aclk, aresetn, out_load, m_valid_reg && state_reg == drsa_pkg::FSM_IDLE)

endmodule

// ----- tb/sv/tb_dma_region_stack_allocator_core.sv -----
`timescale 1ns / 100ps
// self-checking testbench for dma_region_stack_allocator_core: directed and random requests,
// an in-bench allocator predictor and a stream monitor; depends on drsa_pkg and the core rtl
module tb_dma_region_stack_allocator_core;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 32;
    localparam int LONG_HOLD     = 300;
    localparam int PHASE_ITEMS   = 90;
    localparam int NUM_PHASES    = 8;
    localparam int NE            = drsa_pkg::MAX_ENTRIES;
    localparam int SHIFT_MAX     = drsa_pkg::PAGE_SHIFT_MAX;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] bytes;
        logic [3:0]  handle;
    } alloc_request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  handle;
        logic [31:0] addr;
        logic [31:0] buf_offset;
        logic [31:0] dsize;
        logic [4:0]  live;
    } alloc_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [39:0]  s_tdata = '0;   // size[31:0], handle[35:32], zero fill
    logic [1:0]   s_tuser = '0;   // req_type[1:0]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;        // alloc_handle, bus_addr, buf_offset, alloc_size, live_count
    logic [1:0]   m_tuser;        // status[1:0]
    logic         cfg_wr_en = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_wdata = '0;

    // allocator state mirrored by the predictor
    logic [4:0]  page_shift_reg = 5'd12;
    logic [31:0] region_bytes = '0;
    logic [31:0] iova_base_reg = '0;
    logic        slot_live [NE];
    logic [31:0] slot_offset [NE];
    logic [31:0] slot_bytes [NE];
    logic [31:0] top_offset = '0;

    alloc_request_t pending_requests[$];
    alloc_result_t  expected_results[$];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    dma_region_stack_allocator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // apply one request to the mirrored table and return the answer it gives
    function automatic alloc_result_t apply_request(logic [1:0] kind, logic [31:0] bytes,
                                                    logic [3:0] handle);
        alloc_result_t r;
        logic [4:0]  shift;
        logic [32:0] mask;
        logic [32:0] rounded;
        logic [32:0] best;
        logic [32:0] slot_end;
        int          slot;
        int          i;
        r = '0;
        case (kind)
            drsa_pkg::REQ_ALLOC: begin
                shift = (page_shift_reg > SHIFT_MAX) ? 5'(SHIFT_MAX) : page_shift_reg;
                mask = (33'd1 << shift) - 33'd1;
                rounded = ({1'b0, bytes} + mask) & ~mask;
                // space check comes ahead of the slot search
                if ({1'b0, top_offset} + rounded > {1'b0, region_bytes}) begin
                    r.status = drsa_pkg::ST_NO_SPACE;
                end else begin
                    slot = -1;
                    for (i = 0; i < NE; i++)
                        if (!slot_live[i] && slot < 0)
                            slot = i;
                    if (slot < 0) begin
                        r.status = drsa_pkg::ST_TABLE_FULL;
                    end else begin
                        slot_live[slot] = 1'b1;
                        slot_offset[slot] = top_offset;
                        slot_bytes[slot] = rounded[31:0];
                        r.status = drsa_pkg::ST_OK;
                        r.handle = 4'(slot);
                        r.buf_offset = top_offset;
                        r.addr = iova_base_reg + top_offset;
                        r.dsize = rounded[31:0];
                        top_offset = top_offset + rounded[31:0];
                    end
                end
            end
            drsa_pkg::REQ_FREE: begin
                if (!slot_live[handle]) begin
                    r.status = drsa_pkg::ST_BAD_HANDLE;
                end else begin
                    slot_live[handle] = 1'b0;
                    // top falls back to the highest live end
                    best = '0;
                    for (i = 0; i < NE; i++) begin
                        slot_end = {1'b0, slot_offset[i]} + {1'b0, slot_bytes[i]};
                        if (slot_live[i] && slot_end > best)
                            best = slot_end;
                    end
                    top_offset = best[31:0];
                end
            end
            drsa_pkg::REQ_FREE_ALL: begin
                for (i = 0; i < NE; i++)
                    slot_live[i] = 1'b0;
                top_offset = '0;
            end
            default: ;
        endcase
        for (i = 0; i < NE; i++)
            r.live = r.live + 5'(slot_live[i]);
        return r;
    endfunction

    // random request with sizes scaled to the current page and region
    function automatic alloc_request_t random_request();
        alloc_request_t q;
        logic [31:0] page;
        int pick;
        page = 32'd1 << ((page_shift_reg > SHIFT_MAX) ? SHIFT_MAX : page_shift_reg);
        q.handle = 4'($urandom_range(15));
        pick = $urandom_range(99);
        if (pick < 8)
            q.bytes = '0;
        else if (pick < 30)
            q.bytes = $urandom_range(page * 4, 1);
        else if (pick < 60)
            q.bytes = region_bytes / $urandom_range(20, 2) + $urandom_range(page, 0);
        else if (pick < 75)
            q.bytes = $urandom_range(region_bytes >> 2, 0);
        else if (pick < 90)
            q.bytes = $urandom;
        else
            q.bytes = 32'hFFFF_FFFF - $urandom_range(page, 0);
        pick = $urandom_range(99);
        if (pick < 55)
            q.kind = drsa_pkg::REQ_ALLOC;
        else if (pick < 92)
            q.kind = drsa_pkg::REQ_FREE;
        else if (pick < 96)
            q.kind = drsa_pkg::REQ_FREE_ALL;
        else
            q.kind = 2'd3;
        return q;
    endfunction

    task automatic queue_request(input logic [1:0] kind, input logic [31:0] bytes,
                                 input logic [3:0] handle);
        pending_requests.push_back('{kind: kind, bytes: bytes, handle: handle});
    endtask

    // register write, mirrored once it has landed
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            drsa_pkg::CFG_PAGE_SHIFT:  page_shift_reg = value[4:0];
            drsa_pkg::CFG_REGION_SIZE: region_bytes = value;
            drsa_pkg::CFG_IOVA_BASE:   iova_base_reg = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [4:0] shift, input logic [31:0] region,
                             input logic [31:0] base);
        write_register(drsa_pkg::CFG_PAGE_SHIFT, {27'd0, shift});
        write_register(drsa_pkg::CFG_REGION_SIZE, region);
        write_register(drsa_pkg::CFG_IOVA_BASE, base);
    endtask

    // wait until every queued request is answered, then let the engine settle
    task automatic drain_and_settle();
        while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // request driver: offers queued items, predicts each accepted transfer
    always @(posedge aclk) begin : request_driver
        alloc_request_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_request(s_tuser, s_tdata[31:0],
                                                         s_tdata[35:32]));
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nxt = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.kind;
                    s_tdata  <= {4'd0, nxt.handle, nxt.bytes};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor: checks each transfer, drives ready with stalls and long holds
    always @(posedge aclk) begin : result_monitor
        alloc_result_t got;
        alloc_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.status = m_tuser;
                got.handle = m_tdata[3:0];
                got.addr = m_tdata[35:4];
                got.buf_offset = m_tdata[67:36];
                got.dsize = m_tdata[99:68];
                got.live = m_tdata[104:100];
                if (expected_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected result: status %0d handle %0d addr %h",
                                 got.status, got.handle, got.addr);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.handle !== want.handle ||
                        got.addr !== want.addr || got.buf_offset !== want.buf_offset ||
                        got.dsize !== want.dsize || got.live !== want.live) begin
                        if (mismatch_count < 10) begin
                            $display("mismatch exp: st %0d h %0d addr %h off %h size %h live %0d",
                                     want.status, want.handle, want.addr, want.buf_offset,
                                     want.dsize, want.live);
                            $display("         got: st %0d h %0d addr %h off %h size %h live %0d",
                                     got.status, got.handle, got.addr, got.buf_offset,
                                     got.dsize, got.live);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (hold_seen != hold_token) begin
                hold_seen <= hold_token;
                hold_left <= LONG_HOLD;
                m_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int ph;
        int n;
        for (n = 0; n < NE; n++) begin
            slot_live[n] = 1'b0;
            slot_offset[n] = '0;
            slot_bytes[n] = '0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: zero-size allocations fill every slot of the table
        for (n = 0; n < NE; n++)
            queue_request(drsa_pkg::REQ_ALLOC, 32'd0, 4'(n));
        queue_request(drsa_pkg::REQ_ALLOC, 32'd0, 4'd0);          // table full
        queue_request(drsa_pkg::REQ_ALLOC, 32'd1, 4'd0);          // no space beats table full
        queue_request(drsa_pkg::REQ_FREE, 32'd0, 4'd15);
        queue_request(drsa_pkg::REQ_FREE, 32'd0, 4'd15);          // slot no longer live
        queue_request(2'd3, 32'hFFFF_FFFF, 4'd15);                // unused kind
        queue_request(drsa_pkg::REQ_FREE_ALL, 32'd0, 4'd0);
        queue_request(drsa_pkg::REQ_FREE, 32'hFFFF_FFFF, 4'd0);
        drain_and_settle();

        // saturated page shift, full region, base that wraps
        configure(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(drsa_pkg::REQ_ALLOC, 32'hFFFF_FFFF, 4'd0);  // rounds past 32 bits
        queue_request(drsa_pkg::REQ_ALLOC, 32'd1, 4'd0);
        queue_request(drsa_pkg::REQ_ALLOC, 32'hFFE0_0000, 4'd0);
        drain_and_settle();

        // random phases over a spread of settings and flow-control modes
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: configure(5'd0, 32'hFFFF_FFFF, 32'd0);
                1: configure(5'd12, 32'h0001_0000, 32'h8000_0000);
                2: configure(5'd20, 32'hFFFF_FFFF, 32'hFFF0_0000);
                3: configure(5'd3, 32'h0000_0400, $urandom);
                4: configure(5'd31, 32'h00A0_0000, $urandom);
                5: configure(5'd12, $urandom, $urandom);
                6: configure(5'd1, 32'h0000_0100, 32'hFFFF_FFFF);
                default: configure(5'd16, 32'hFFFF_FFFF, $urandom);
            endcase
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 65; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 65; end
                default: begin tx_idle_pct = 27; rx_stall_pct = 27; end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
                pending_requests.push_back(random_request());
            // long receiver hold while the sender keeps offering
            if (ph % 4 == 0)
                hold_token++;
            drain_and_settle();
        end

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
